FILE: rtl/dmaae_pkg.sv
// Shared types, constants and helpers for the four-channel DMA address engine.
`default_nettype none

package dmaae_pkg;

    // Sizes of the channel array and of the count registers.
    localparam int NUM_CHANNELS = 4;
    localparam int COUNT_WIDTH  = 16;

    // Fixed field widths of the request and result items.
    localparam int CH_W    = 2;
    localparam int ADDR_W  = 32;
    localparam int CTRL_W  = 16;
    localparam int AMODE_W = 2;

    // Bit positions inside the control word.
    localparam int CTRL_EN        = 15;
    localparam int CTRL_IRQ       = 14;
    localparam int CTRL_WORD      = 10;
    localparam int CTRL_REPEAT    = 9;
    localparam int CTRL_SMODE_LSB = 7;
    localparam int CTRL_DMODE_LSB = 5;

    // Address step sizes for word and halfword units.
    localparam logic [ADDR_W-1:0] STEP_WORD = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] STEP_HALF = ADDR_W'(2);

    // Port packing widths, padded to whole bytes.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_SRC  = 2'd0,
        REG_DST  = 2'd1,
        REG_CNT  = 2'd2,
        REG_CTRL = 2'd3
    } t_reg_sel;

    typedef enum logic [AMODE_W-1:0] {
        AM_INC        = 2'd0,
        AM_DEC        = 2'd1,
        AM_FIXED      = 2'd2,
        AM_INC_RELOAD = 2'd3
    } t_addr_mode;

    // One incoming request.
    typedef struct packed {
        t_op               op;
        logic [CH_W-1:0]   channel;
        t_reg_sel          sel;
        logic [ADDR_W-1:0] value;
    } t_item;

    // Latched and working registers of one channel.
    typedef struct packed {
        logic [ADDR_W-1:0]      src_rl;
        logic [ADDR_W-1:0]      dst_rl;
        logic [COUNT_WIDTH-1:0] cnt_rl;
        logic [CTRL_W-1:0]      ctrl;
        logic [ADDR_W-1:0]      src;
        logic [ADDR_W-1:0]      dst;
        logic [COUNT_WIDTH-1:0] cnt;
    } t_chan;

    // One result item.
    typedef struct packed {
        logic              irq_request;
        logic              block_done;
        logic              word_transfer;
        logic [ADDR_W-1:0] dest_address;
        logic [ADDR_W-1:0] source_address;
        logic [CH_W-1:0]   channel_out;
        logic              transfer_valid;
    } t_result;

    // Advance an address by one unit according to its mode.
    function automatic logic [ADDR_W-1:0] step_addr(
        input logic [ADDR_W-1:0] addr,
        input t_addr_mode        amode,
        input logic              word
    );
        logic [ADDR_W-1:0] size;
        size = word ? STEP_WORD : STEP_HALF;
        case (amode)
            AM_DEC:   step_addr = addr - size;
            AM_FIXED: step_addr = addr;
            default:  step_addr = addr + size;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dmaae_sched.sv
// Register-write decode, channel priority pick and one-unit address step.
`default_nettype none

module dmaae_sched
    import dmaae_pkg::*;
(
    input  t_item                    i_item,
    input  t_chan [NUM_CHANNELS-1:0] i_chan,
    output t_chan [NUM_CHANNELS-1:0] o_chan,
    output t_result                  o_result
);

    always_comb begin
        logic                   found;
        t_chan                  c;
        t_addr_mode             dmode;
        t_addr_mode             smode;
        logic                   word;
        logic [COUNT_WIDTH-1:0] left;
        logic [CTRL_W-1:0]      nw;

        o_chan   = i_chan;
        o_result = '0;
        found    = 1'b0;

        for (int k = 0; k < NUM_CHANNELS; k++) begin
            c     = i_chan[k];
            dmode = t_addr_mode'(c.ctrl[CTRL_DMODE_LSB +: AMODE_W]);
            smode = t_addr_mode'(c.ctrl[CTRL_SMODE_LSB +: AMODE_W]);
            word  = c.ctrl[CTRL_WORD];
            nw    = i_item.value[CTRL_W-1:0];
            left  = '0;

            if (i_item.op == OP_WRITE) begin
                // Store into the addressed latched register.
                if (int'(i_item.channel) == k) begin
                    unique case (i_item.sel)
                        REG_SRC: c.src_rl = i_item.value;
                        REG_DST: c.dst_rl = i_item.value;
                        REG_CNT: c.cnt_rl = i_item.value[COUNT_WIDTH-1:0];
                        REG_CTRL: begin
                            // A rising enable loads the working copies.
                            if (!c.ctrl[CTRL_EN] && nw[CTRL_EN]) begin
                                c.src = c.src_rl;
                                c.dst = c.dst_rl;
                                c.cnt = c.cnt_rl;
                            end
                            c.ctrl = nw;
                        end
                        default: c.ctrl = c.ctrl;
                    endcase
                end
            end else if (!found && c.ctrl[CTRL_EN]) begin
                // The lowest enabled channel is served on a tick.
                found                = 1'b1;
                o_result.channel_out = CH_W'(k);
                if (c.cnt != '0) begin
                    o_result.transfer_valid = 1'b1;
                    o_result.source_address = c.src;
                    o_result.dest_address   = c.dst;
                    o_result.word_transfer  = word;
                    c.src = step_addr(c.src, smode, word);
                    c.dst = step_addr(c.dst, dmode, word);
                    left  = c.cnt - COUNT_WIDTH'(1);
                    c.cnt = left;
                end
                // Completion: reload on repeat, otherwise drop the enable.
                if (left == '0) begin
                    o_result.block_done  = 1'b1;
                    o_result.irq_request = c.ctrl[CTRL_IRQ];
                    if (c.ctrl[CTRL_REPEAT]) begin
                        c.cnt = c.cnt_rl;
                        if (dmode == AM_INC_RELOAD) begin
                            c.src = c.src_rl;
                            c.dst = c.dst_rl;
                        end
                    end else begin
                        c.ctrl[CTRL_EN] = 1'b0;
                    end
                end
            end
            o_chan[k] = c;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dmaae_regs.sv
// Per-channel latched and working register bank.
`default_nettype none

module dmaae_regs
    import dmaae_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  t_chan [NUM_CHANNELS-1:0] i_next,
    output t_chan [NUM_CHANNELS-1:0] o_chan
);

    t_chan [NUM_CHANNELS-1:0] r_chan;

    // All channels come out of reset cleared and disabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
        end else if (i_load) begin
            r_chan <= i_next;
        end
    end

    assign o_chan = r_chan;

endmodule

`default_nettype wire

FILE: rtl/four_channel_dma_address_engine_core.sv
// Top level of the four-channel DMA address engine.
//
// Requests arrive on the slave stream: tuser carries the kind (0 register
// write, 1 tick) and tdata carries channel, register select and write value.
// Every request produces exactly one result on the master stream. A tick
// serves the lowest-numbered enabled channel: it reports the source and
// destination address of one transfer unit, steps both addresses and counts
// down, and flags completion and interrupt when the count runs out. Register
// writes and ticks with no enabled channel return an all-zero result.
//
// The result appears in the cycle after its request is taken. A new request is
// taken every cycle unless the receiver stalls; the output register is the only
// storage between the two sides, and the register bank is updated in the same
// cycle a request is taken. When the receiver stalls, the held result stays
// stable and the slave side takes a request only in the cycle the held result leaves.
//
// Synchronous active-low reset clears every channel register, leaving all
// channels disabled, and empties the output register.
`default_nettype none

module four_channel_dma_address_engine_core
    import dmaae_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata, lowest bit up: channel[1:0], register_select[3:2],
    // write_value[35:4], zero pad[39:36].
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // tuser: mode[0].
    input  logic [0:0]            i_s_tuser,
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata, lowest bit up: transfer_valid[0], channel_out[2:1],
    // source_address[34:3], dest_address[66:35], word_transfer[67],
    // block_done[68], irq_request[69], zero pad[71:70].
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    t_item                    item;
    t_chan [NUM_CHANNELS-1:0] chan;
    t_chan [NUM_CHANNELS-1:0] chan_next;
    t_result                  result;
    logic                     accept;

    logic                     r_valid;
    logic                     n_valid;
    t_result                  r_result;

    // Unpack the request.
    assign item.op      = t_op'(i_s_tuser[0]);
    assign item.channel = i_s_tdata[1:0];
    assign item.sel     = t_reg_sel'(i_s_tdata[3:2]);
    assign item.value   = i_s_tdata[35:4];

    assign o_s_tready = !r_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    dmaae_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_next  (chan_next),
        .o_chan  (chan)
    );

    dmaae_sched u_sched (
        .i_item   (item),
        .i_chan   (chan),
        .o_chan   (chan_next),
        .o_result (result)
    );

    // Output register occupancy.
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_result};

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking stream testbench for the four-channel DMA address engine core.
module testbench;
    import dmaae_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no request or result moving before the run is declared hung.
    localparam int QUIET_LIMIT = 5000;
    // Mismatch lines printed before further ones are only counted.
    localparam int PRINT_CAP   = 40;
    // Random requests per traffic phase.
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES  = 4;

    // Control word helpers used by the directed programs.
    localparam logic [31:0] CW_EN     = 32'h1 << CTRL_EN;
    localparam logic [31:0] CW_IRQ    = 32'h1 << CTRL_IRQ;
    localparam logic [31:0] CW_WORD   = 32'h1 << CTRL_WORD;
    localparam logic [31:0] CW_REPEAT = 32'h1 << CTRL_REPEAT;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic [0:0]            i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    four_channel_dma_address_engine_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_item   request_q[$];
    t_item   held_request;
    t_result transfer_q[$];
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;

    // Shadow copy of every channel's latched and working registers.
    logic [ADDR_W-1:0]      src_latch [NUM_CHANNELS];
    logic [ADDR_W-1:0]      dst_latch [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] cnt_latch [NUM_CHANNELS];
    logic [CTRL_W-1:0]      ctrl_shadow [NUM_CHANNELS];
    logic [ADDR_W-1:0]      src_work [NUM_CHANNELS];
    logic [ADDR_W-1:0]      dst_work [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] cnt_work [NUM_CHANNELS];

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic logic [ADDR_W-1:0] advance_address(
        logic [ADDR_W-1:0] addr,
        t_addr_mode        amode,
        logic              word
    );
        logic [ADDR_W-1:0] delta;
        delta = word ? 32'd4 : 32'd2;
        if (amode == AM_DEC)
            return addr - delta;
        if (amode == AM_FIXED)
            return addr;
        return addr + delta;
    endfunction

    // Apply one request to the shadow registers and return the transfer it reports.
    function automatic t_result predict_transfer(t_item req);
        t_result           res;
        logic [CTRL_W-1:0] cw;
        t_addr_mode        smode;
        t_addr_mode        dmode;
        logic              served;
        int                ch;
        res    = '0;
        served = 1'b0;
        ch     = int'(req.channel);
        if (req.op == OP_WRITE) begin
            case (req.sel)
                REG_SRC: src_latch[ch] = req.value;
                REG_DST: dst_latch[ch] = req.value;
                REG_CNT: cnt_latch[ch] = req.value[COUNT_WIDTH-1:0];
                default: begin
                    // A rising enable loads the working copies.
                    if (!ctrl_shadow[ch][CTRL_EN] && req.value[CTRL_EN]) begin
                        src_work[ch] = src_latch[ch];
                        dst_work[ch] = dst_latch[ch];
                        cnt_work[ch] = cnt_latch[ch];
                    end
                    ctrl_shadow[ch] = req.value[CTRL_W-1:0];
                end
            endcase
            return res;
        end
        for (ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (!served && ctrl_shadow[ch][CTRL_EN]) begin
                served = 1'b1;
                cw     = ctrl_shadow[ch];
                smode  = t_addr_mode'(cw[CTRL_SMODE_LSB +: AMODE_W]);
                dmode  = t_addr_mode'(cw[CTRL_DMODE_LSB +: AMODE_W]);
                res.channel_out = CH_W'(ch);
                if (cnt_work[ch] != '0) begin
                    res.transfer_valid = 1'b1;
                    res.source_address = src_work[ch];
                    res.dest_address   = dst_work[ch];
                    res.word_transfer  = cw[CTRL_WORD];
                    src_work[ch] = advance_address(src_work[ch], smode, cw[CTRL_WORD]);
                    dst_work[ch] = advance_address(dst_work[ch], dmode, cw[CTRL_WORD]);
                    cnt_work[ch] = cnt_work[ch] - COUNT_WIDTH'(1);
                end
                // Completion: reload on repeat, otherwise drop the enable.
                if (cnt_work[ch] == '0) begin
                    res.block_done  = 1'b1;
                    res.irq_request = cw[CTRL_IRQ];
                    if (cw[CTRL_REPEAT]) begin
                        cnt_work[ch] = cnt_latch[ch];
                        if (dmode == AM_INC_RELOAD) begin
                            src_work[ch] = src_latch[ch];
                            dst_work[ch] = dst_latch[ch];
                        end
                    end else begin
                        ctrl_shadow[ch][CTRL_EN] = 1'b0;
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic push_request(t_op op, int ch, t_reg_sel sel, logic [31:0] value);
        t_item req;
        req.op      = op;
        req.channel = CH_W'(ch);
        req.sel     = sel;
        req.value   = value;
        request_q.push_back(req);
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_request(OP_TICK, $urandom_range(0, 3), t_reg_sel'($urandom_range(0, 3)),
                                $urandom);
    endtask

    // Program one channel with random content, then let it run for a few ticks.
    task automatic push_program(output int pushed);
        int          ch;
        int          ticks;
        logic [31:0] cw;
        logic [31:0] cnt;
        pushed = 0;
        ch     = $urandom_range(0, NUM_CHANNELS - 1);
        ticks  = $urandom_range(1, 8);
        if ($urandom_range(0, 1) == 0) begin
            cw = $urandom;
            cw[CTRL_EN] = 1'b0;
            push_request(OP_WRITE, ch, REG_CTRL, cw);
            pushed++;
        end
        cnt = $urandom;
        if ($urandom_range(0, 99) < 75)
            cnt[15:0] = 16'($urandom_range(0, 5));
        push_request(OP_WRITE, ch, REG_SRC, $urandom);
        push_request(OP_WRITE, ch, REG_DST, $urandom);
        push_request(OP_WRITE, ch, REG_CNT, cnt);
        cw = $urandom;
        cw[CTRL_EN] = ($urandom_range(0, 99) < 85);
        push_request(OP_WRITE, ch, REG_CTRL, cw);
        push_ticks(ticks);
        pushed += 4 + ticks;
    endtask

    // Short programs over the field extremes and every completion case.
    task automatic push_directed();
        push_request(OP_TICK, 0, REG_SRC, 32'h0);
        // Channel 3: halfword, repeat with increment-reload, irq, source wraps.
        push_request(OP_WRITE, 3, REG_SRC, 32'hFFFF_FFFE);
        push_request(OP_WRITE, 3, REG_DST, 32'h0000_0000);
        push_request(OP_WRITE, 3, REG_CNT, 32'hFFFF_0002);
        push_request(OP_WRITE, 3, REG_CTRL,
                     32'h1234_0000 | CW_EN | CW_IRQ | CW_REPEAT | (32'(AM_INC_RELOAD) << 5));
        push_request(OP_TICK, 3, REG_CTRL, 32'hFFFF_FFFF);
        push_request(OP_TICK, 0, REG_SRC, 32'h0);
        push_request(OP_TICK, 0, REG_SRC, 32'h0);
        // Channel 0 enabled with a zero count completes at once.
        push_request(OP_WRITE, 0, REG_CNT, 32'h0);
        push_request(OP_WRITE, 0, REG_CTRL, CW_EN);
        push_request(OP_TICK, 0, REG_SRC, 32'h0);
        // Channel 1 outranks channel 3; word units, decrementing source.
        push_request(OP_WRITE, 1, REG_SRC, 32'hFFFF_FFFF);
        push_request(OP_WRITE, 1, REG_DST, 32'h8000_0000);
        push_request(OP_WRITE, 1, REG_CNT, 32'h0000_FFFF);
        push_request(OP_WRITE, 1, REG_CTRL,
                     CW_EN | CW_WORD | (32'(AM_DEC) << 7) | (32'(AM_FIXED) << 5));
        push_request(OP_TICK, 0, REG_SRC, 32'h0);
        // Control rewrite while enabled keeps the working copies.
        push_request(OP_WRITE, 1, REG_CTRL,
                     CW_EN | CW_WORD | (32'(AM_FIXED) << 7) | (32'(AM_DEC) << 5));
        push_request(OP_TICK, 0, REG_SRC, 32'h0);
        push_request(OP_WRITE, 1, REG_CTRL, 32'h0);
        // Every control bit set on a zero-count channel: repeat reloads zero.
        push_request(OP_WRITE, 2, REG_CTRL, 32'hFFFF_FFFF);
        push_request(OP_TICK, 0, REG_SRC, 32'h0);
        push_request(OP_TICK, 0, REG_SRC, 32'h0);
        push_request(OP_WRITE, 2, REG_CTRL, 32'h0);
        push_request(OP_TICK, 0, REG_SRC, 32'h0);
    endtask

    // Request driver: presents queued requests, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                transfer_q.push_back(predict_transfer(held_request));
            if (!i_s_tvalid || o_s_tready) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    held_request = request_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {4'b0, held_request.value, held_request.sel,
                                   held_request.channel};
                    i_s_tuser  <= held_request.op;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted result and stalls at random.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = t_result'(o_m_tdata[$bits(t_result)-1:0]);
                if (transfer_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'h0, 32'h0);
                end else begin
                    want = transfer_q.pop_front();
                    if (got.transfer_valid != want.transfer_valid)
                        report_mismatch("transfer_valid", 32'(got.transfer_valid),
                                        32'(want.transfer_valid));
                    if (got.channel_out != want.channel_out)
                        report_mismatch("channel_out", 32'(got.channel_out),
                                        32'(want.channel_out));
                    if (got.source_address != want.source_address)
                        report_mismatch("source_address", got.source_address,
                                        want.source_address);
                    if (got.dest_address != want.dest_address)
                        report_mismatch("dest_address", got.dest_address, want.dest_address);
                    if (got.word_transfer != want.word_transfer)
                        report_mismatch("word_transfer", 32'(got.word_transfer),
                                        32'(want.word_transfer));
                    if (got.block_done != want.block_done)
                        report_mismatch("block_done", 32'(got.block_done),
                                        32'(want.block_done));
                    if (got.irq_request != want.irq_request)
                        report_mismatch("irq_request", 32'(got.irq_request),
                                        32'(want.irq_request));
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles where neither side moves anything.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Stimulus sequencing through the traffic phases.
    initial begin
        int send_pct [NUM_PHASES];
        int recv_pct [NUM_PHASES];
        int issued;
        int pushed;
        send_pct = '{0, 78, 0, 32};
        recv_pct = '{0, 0, 78, 32};
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            src_latch[ch]   = '0;
            dst_latch[ch]   = '0;
            cnt_latch[ch]   = '0;
            ctrl_shadow[ch] = '0;
            src_work[ch]    = '0;
            dst_work[ch]    = '0;
            cnt_work[ch]    = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            if (phase == 0)
                push_directed();
            issued = 0;
            while (issued < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 15) begin
                    push_request(t_op'($urandom_range(0, 1)), $urandom_range(0, 3),
                                 t_reg_sel'($urandom_range(0, 3)), $urandom);
                    issued++;
                end else begin
                    push_program(pushed);
                    issued += pushed;
                end
            end
            // Hold the sender until every outstanding result has come back.
            while (request_q.size() != 0 || i_s_tvalid || transfer_q.size() != 0)
                @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (transfer_q.size() != 0)
            report_mismatch("results never delivered", 32'(transfer_q.size()), 32'h0);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/dmaae_pkg.sv
rtl/dmaae_sched.sv
rtl/dmaae_regs.sv
rtl/four_channel_dma_address_engine_core.sv
verif/testbench.sv
